@@ hdl/hvt_pkg.sv @@
`timescale 1ns / 1ps
package hvt_pkg;

	localparam int NumRows  = 4;
	localparam int NumCols  = 4;
	localparam int CompW    = 32;
	localparam int CoefW    = 16;
	localparam int CoefFrac = 8;
	localparam int RowW     = NumCols * CoefW;
	localparam int ProdW    = CompW + CoefW;
	localparam int SumW     = ProdW + 2;
	localparam int ShiftW   = SumW - CoefFrac;

	typedef logic signed [CompW-1:0]  comp_t;
	typedef logic signed [ProdW-1:0]  prod_t;
	typedef logic signed [SumW-1:0]   sum_t;
	typedef logic signed [ShiftW-1:0] shift_t;
	typedef logic [RowW-1:0]          row_t;

	typedef enum logic [1:0] {
		REG_ROW0 = 2'd0,
		REG_ROW1 = 2'd1,
		REG_ROW2 = 2'd2,
		REG_ROW3 = 2'd3
	} reg_idx_t;

	// identity matrix, 1.0 is 0x0100 in Q8.8
	localparam row_t RowReset [NumRows] = '{
		64'h0000_0000_0000_0100,
		64'h0000_0000_0100_0000,
		64'h0000_0100_0000_0000,
		64'h0100_0000_0000_0000
	};

	localparam comp_t CompMax = 32'h7FFF_FFFF;
	localparam comp_t CompMin = 32'h8000_0000;

	typedef struct packed {
		comp_t in_x;
		comp_t in_y;
		comp_t in_z;
		comp_t in_h;
	} in_word_t;

	typedef struct packed {
		comp_t out_x;
		comp_t out_y;
		comp_t out_z;
		comp_t out_h;
		logic  saturated;
	} out_word_t;

endpackage

@@ hdl/homogeneous_vertex_transform.sv @@
`timescale 1ns / 1ps
// 4x4 fixed-point matrix times homogeneous vector (x, y, z, h).
// input channel: in_valid / in_ready, one vector word of four signed Q16.16
// components per transfer. output channel: out_valid / out_ready, one word
// of four saturated signed Q16.16 components plus a saturated flag.
// matrix rows are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while idle, which the block does not enforce.
// each row packs four signed Q8.8 coefficients, element j in bits 16j+15..16j.
// four row lanes run in parallel: a multiply stage, an adder stage, then the
// merge stage floors, clamps and registers the result word.
// throughput: one word per cycle unless stalled; four 16x32 multipliers per lane.
// reset loads the identity matrix and empties the pipeline.
// when the receiver stalls, the output register and a one-word skid register
// absorb what is in flight; in_ready drops once the skid register is full
// and the whole pipeline holds until the receiver takes a word.
module homogeneous_vertex_transform (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hvt_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output hvt_pkg::out_word_t out_data,
	input  logic               cfg_we,
	input  hvt_pkg::reg_idx_t  cfg_index,
	input  hvt_pkg::row_t      cfg_data
);
	import hvt_pkg::*;

	row_t row_q [NumRows];
	sum_t sums [NumRows];
	logic en;
	logic v_s1;
	logic v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRows; i++) begin
				row_q[i] <= RowReset[i];
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW0: row_q[0] <= cfg_data;
				REG_ROW1: row_q[1] <= cfg_data;
				REG_ROW2: row_q[2] <= cfg_data;
				REG_ROW3: row_q[3] <= cfg_data;
				default:  row_q[0] <= row_q[0];
			endcase
		end
	end

	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	for (genvar i = 0; i < NumRows; i++) begin : g_lane
		hvt_lane u_lane (
			.clk    (clk),
			.en     (en),
			.coefs  (row_q[i]),
			.vec    (in_data),
			.sum_s2 (sums[i])
		);
	end

	hvt_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (v_s2),
		.up_ready  (en),
		.sums      (sums),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ hdl/hvt_lane.sv @@
`timescale 1ns / 1ps
module hvt_lane (
	input  logic            clk,
	input  logic            en,
	input  hvt_pkg::row_t   coefs,
	input  hvt_pkg::in_word_t vec,
	output hvt_pkg::sum_t   sum_s2
);
	import hvt_pkg::*;

	comp_t comp [NumCols];
	prod_t prod_s1 [NumCols];
	sum_t  sum_c;

	assign comp[0] = vec.in_x;
	assign comp[1] = vec.in_y;
	assign comp[2] = vec.in_z;
	assign comp[3] = vec.in_h;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NumCols; j++) begin
				prod_s1[j] <= $signed(coefs[j*CoefW +: CoefW]) * comp[j];
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int j = 0; j < NumCols; j++) begin
			sum_c = sum_c + sum_t'(prod_s1[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum_c;
		end
	end

endmodule

@@ hdl/hvt_merge.sv @@
`timescale 1ns / 1ps
module hvt_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  hvt_pkg::sum_t      sums [hvt_pkg::NumRows],
	output logic               out_valid,
	input  logic               out_ready,
	output hvt_pkg::out_word_t out_data
);
	import hvt_pkg::*;

	shift_t    shifted [NumRows];
	comp_t     res [NumRows];
	logic      clamp [NumRows];
	out_word_t word_c;
	out_word_t out_q;
	out_word_t skid_q;
	logic      out_valid_q;
	logic      skid_valid_q;

	// floor back to Q16.16, then clamp to 32 bits
	always_comb begin
		for (int i = 0; i < NumRows; i++) begin
			shifted[i] = shift_t'(sums[i] >>> CoefFrac);
			clamp[i]   = shifted[i][ShiftW-1:CompW-1] !=
				{(ShiftW-CompW+1){shifted[i][CompW-1]}};
			if (!clamp[i]) begin
				res[i] = shifted[i][CompW-1:0];
			end else if (shifted[i][ShiftW-1]) begin
				res[i] = CompMin;
			end else begin
				res[i] = CompMax;
			end
		end
		word_c.out_x     = res[0];
		word_c.out_y     = res[1];
		word_c.out_z     = res[2];
		word_c.out_h     = res[3];
		word_c.saturated = clamp[0] | clamp[1] | clamp[2] | clamp[3];
	end

	assign up_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || up_valid;
			skid_valid_q <= 1'b0;
		end else if (up_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	// skid register catches the word in flight while the receiver stalls
	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : word_c;
		end else if (up_valid && !skid_valid_q) begin
			skid_q <= word_c;
		end
	end

endmodule

@@ hdl/hvt_checker.sv @@
`timescale 1ns / 1ps
module hvt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input hvt_pkg::in_word_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input hvt_pkg::out_word_t out_data
);
	import hvt_pkg::*;

	// waiting input word stays put
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input word changed while waiting");

	// stalled word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// a set flag means some component sits at a clamp value
	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |->
			out_data.out_x == CompMax || out_data.out_x == CompMin ||
			out_data.out_y == CompMax || out_data.out_y == CompMin ||
			out_data.out_z == CompMax || out_data.out_z == CompMin ||
			out_data.out_h == CompMax || out_data.out_h == CompMin)
		else $error("saturated flag without a clamped component");

	// backpressure only comes from a full output side
	a_ready_low: assert property (@(posedge clk)
		!in_ready |-> out_valid)
		else $error("in_ready low with empty output");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("out_valid during reset");

endmodule

bind homogeneous_vertex_transform hvt_checker u_hvt_checker (.*);

@@ sim/vertex_transform_checker.sv @@
`timescale 1ns / 1ps
module vertex_transform_checker
	import hvt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_word_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_word_t out_data,
	input  logic      cfg_we,
	input  reg_idx_t  cfg_index,
	input  row_t      cfg_data,
	output int        outstanding,
	output int        mismatches,
	output int        words_checked,
	output int        words_saturated
);

	row_t      matrix [NumRows];
	out_word_t predicted_q [$];

	function automatic out_word_t transform_vertex(input in_word_t v);
		longint    comp [NumCols];
		longint    acc;
		comp_t     lane [NumRows];
		logic      clamped;
		out_word_t r;
		int        i;
		int        j;
		comp[0] = longint'($signed(v.in_x));
		comp[1] = longint'($signed(v.in_y));
		comp[2] = longint'($signed(v.in_z));
		comp[3] = longint'($signed(v.in_h));
		clamped = 1'b0;
		for (i = 0; i < NumRows; i++) begin
			acc = 0;
			for (j = 0; j < NumCols; j++) begin
				acc += longint'($signed(matrix[i][CoefW*j +: CoefW])) * comp[j];
			end
			// arithmetic shift drops the fraction bits toward minus infinity
			acc = acc >>> CoefFrac;
			if (acc > longint'(CompMax)) begin
				acc = longint'(CompMax);
				clamped = 1'b1;
			end else if (acc < longint'(CompMin)) begin
				acc = longint'(CompMin);
				clamped = 1'b1;
			end
			lane[i] = acc[CompW-1:0];
		end
		r.out_x     = lane[0];
		r.out_y     = lane[1];
		r.out_z     = lane[2];
		r.out_h     = lane[3];
		r.saturated = clamped;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		logic      bad;
		if (!arst_n) begin
			matrix <= RowReset;
			predicted_q.delete();
			outstanding     <= 0;
			mismatches      = 0;
			words_checked   = 0;
			words_saturated = 0;
		end else begin
			if (cfg_we) begin
				matrix[cfg_index] <= cfg_data;
			end
			if (in_valid && in_ready) begin
				predicted_q.push_back(transform_vertex(in_data));
			end
			if (out_valid && out_ready) begin
				if (predicted_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: output word with nothing pending: x=%h y=%h z=%h h=%h sat=%b",
							$realtime, out_data.out_x, out_data.out_y, out_data.out_z,
							out_data.out_h, out_data.saturated);
					end
				end else begin
					want = predicted_q.pop_front();
					words_checked++;
					if (want.saturated) begin
						words_saturated++;
					end
					bad = (out_data.out_x !== want.out_x) || (out_data.out_y !== want.out_y) ||
						(out_data.out_z !== want.out_z) || (out_data.out_h !== want.out_h) ||
						(out_data.saturated !== want.saturated);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch, expected x=%h y=%h z=%h h=%h sat=%b",
								$realtime, want.out_x, want.out_y, want.out_z, want.out_h,
								want.saturated);
							$display("%0t:               got x=%h y=%h z=%h h=%h sat=%b",
								$realtime, out_data.out_x, out_data.out_y, out_data.out_z,
								out_data.out_h, out_data.saturated);
						end
					end
				end
			end
			outstanding <= predicted_q.size();
		end
	end

endmodule

@@ sim/homogeneous_vertex_transform_tb.sv @@
`timescale 1ns / 1ps
module homogeneous_vertex_transform_tb;
	import hvt_pkg::*;

	localparam int RandPhases    = 12;
	localparam int WordsPerPhase = 50;
	localparam int DrainCycles   = 8;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;
	logic      cfg_we;
	reg_idx_t  cfg_index;
	row_t      cfg_data;

	int tx_idle_pct = 32;
	int rx_idle_pct = 65;
	int settings_used = 1;
	int outstanding;
	int mismatches;
	int words_checked;
	int words_saturated;

	homogeneous_vertex_transform u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	vertex_transform_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.outstanding     (outstanding),
		.mismatches      (mismatches),
		.words_checked   (words_checked),
		.words_saturated (words_saturated)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic in_word_t vertex(input comp_t x, input comp_t y, input comp_t z,
		input comp_t h);
		in_word_t w;
		w.in_x = x;
		w.in_y = y;
		w.in_z = z;
		w.in_h = h;
		return w;
	endfunction

	function automatic comp_t pick_comp();
		case ($urandom_range(9))
			0: return CompMax;
			1: return CompMin;
			2, 3, 4: return comp_t'($urandom_range(2097152) - 1048576);
			default: return comp_t'($urandom);
		endcase
	endfunction

	// modest coefficients keep most results inside the 32-bit range
	function automatic logic [CoefW-1:0] pick_coef(input bit modest);
		if (modest) begin
			return CoefW'($urandom_range(1536) - 768);
		end
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return '0;
			3, 4: return CoefW'($urandom_range(1536) - 768);
			default: return CoefW'($urandom);
		endcase
	endfunction

	task automatic send_vertex(input in_word_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load_matrix(input row_t rows [NumRows]);
		reg_idx_t idx;
		int       i;
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		idx = idx.first();
		for (i = 0; i < NumRows; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= rows[i];
			@(posedge clk);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		row_t     m [NumRows];
		in_word_t w;
		bit       affine;
		int       p;
		int       k;
		int       i;
		int       j;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_ROW0;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// identity after reset, words come back unchanged
		send_vertex(vertex('0, '0, '0, '0));
		send_vertex(vertex(CompMax, CompMax, CompMax, CompMax));
		send_vertex(vertex(CompMin, CompMin, CompMin, CompMin));
		send_vertex(vertex(CompMax, CompMin, -1, 1));
		send_vertex(vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_8000, 32'hFFFE_8000));
		send_vertex(vertex(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'hEDCB_A987));

		m = '{64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
			64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF};
		load_matrix(m);
		send_vertex(vertex(CompMax, CompMax, CompMax, CompMax));
		send_vertex(vertex(CompMin, CompMin, CompMin, CompMin));
		send_vertex(vertex(1, 0, 0, 0));
		send_vertex(vertex('0, '0, '0, '0));

		m = '{64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
			64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000};
		load_matrix(m);
		send_vertex(vertex(CompMin, CompMin, CompMin, CompMin));
		send_vertex(vertex(CompMax, CompMax, CompMax, CompMax));
		send_vertex(vertex(1, 1, 1, 1));
		send_vertex(vertex(-1, 0, 0, 0));

		// tiny and half coefficients, negative sums must floor
		m = '{64'h0000_0000_0000_0001, 64'h0000_0000_FFFF_0000,
			64'h0000_0080_0000_0000, 64'hFF80_0000_0000_0000};
		load_matrix(m);
		send_vertex(vertex(-1, 1, -1, 1));
		send_vertex(vertex(1, -1, 1, -1));
		send_vertex(vertex(-257, 255, -3, 3));

		// one lane clamps while the others stay in range
		m = '{64'h0000_0000_0000_7FFF, 64'h0000_0000_8000_0000,
			64'h0000_0100_0000_0000, 64'h0100_0000_0000_0000};
		load_matrix(m);
		send_vertex(vertex(CompMax, 1, 7, -7));
		send_vertex(vertex('0, CompMax, 3, 4));

		for (p = 0; p < RandPhases; p++) begin
			if (p == RandPhases / 3) begin
				tx_idle_pct = 65;
				rx_idle_pct <= 32;
			end else if (p == 2 * RandPhases / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			// even phases hold an affine transform, odd ones anything
			affine = (p % 2 == 0);
			for (i = 0; i < NumRows; i++) begin
				for (j = 0; j < NumCols; j++) begin
					m[i][CoefW*j +: CoefW] = pick_coef(affine);
				end
			end
			if (affine) begin
				m[NumRows-1] = RowReset[NumRows-1];
			end
			load_matrix(m);
			for (k = 0; k < WordsPerPhase; k++) begin
				w = vertex(pick_comp(), pick_comp(), pick_comp(), pick_comp());
				if (affine && $urandom_range(1)) begin
					w.in_h = 32'h0001_0000;
				end
				send_vertex(w);
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DrainCycles) @(posedge clk);
		$display("transformed %0d vertices under %0d matrix settings, %0d of them clamped",
			words_checked, settings_used, words_saturated);
		$display("idle mixes: sender 32/receiver 65, sender 65/receiver 32, none");
		if (mismatches == 0 && outstanding == 0) begin
			$display("homogeneous_vertex_transform_tb: clean");
		end else begin
			$display("homogeneous_vertex_transform_tb: errors");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d words outstanding", outstanding);
		$display("homogeneous_vertex_transform_tb: errors");
		$finish;
	end

endmodule
